/* rtl/core/cpc_pkg.sv */
package cpc_pkg;

  // Field widths and fixed-point format
  localparam int COORD_WIDTH    = 16;
  localparam int ANGLE_WIDTH    = 16;
  localparam int GUARD_BITS     = 8;
  localparam int DATA_W         = COORD_WIDTH + GUARD_BITS + 3;
  localparam int Z_W            = 32;
  localparam int ITERATIONS_DEF = 16;
  localparam int TABLE_LEN      = 24;

  // Gain correction: round(0.60725293500888 * 2^20)
  localparam int GAIN_Q20      = 636751;
  localparam int GAIN_FRAC     = 20;
  localparam int GAIN_W        = 21;
  localparam int PROD_W        = DATA_W + GAIN_W;
  localparam int DESCALE_SHIFT = GUARD_BITS + GAIN_FRAC;

  // Front/back decoupling queue
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_TO_POLAR = 1'b0,
    OP_TO_CART  = 1'b1
  } opcode_t;

  typedef logic signed [DATA_W-1:0]      data_t;
  typedef logic [Z_W-1:0]                z_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [COORD_WIDTH:0]   coord_ext_t;
  typedef logic signed [ANGLE_WIDTH-1:0] angle_t;

  // Quarter turn in binary angle units
  localparam angle_t QUARTER_POS = angle_t'(16384);
  localparam angle_t QUARTER_NEG = angle_t'(-16384);

  typedef struct packed {
    opcode_t                         opcode;
    logic signed [COORD_WIDTH-1:0]   x_in;
    logic signed [COORD_WIDTH-1:0]   y_in;
    logic [COORD_WIDTH-1:0]          radius_in;
    logic signed [ANGLE_WIDTH-1:0]   angle_in;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0]   x_out;
    logic signed [COORD_WIDTH-1:0]   y_out;
    logic [COORD_WIDTH-1:0]          radius_out;
    logic signed [ANGLE_WIDTH-1:0]   angle_out;
  } out_item_t;

  // Classified work item between front and back
  typedef struct packed {
    logic  rot;
    logic  zero;
    data_t x;
    data_t y;
    z_t    z;
  } work_t;

  // atan(2^-i), 2^32 units per turn, rounded to nearest
  function automatic z_t atan_entry(input int idx);
    z_t v;
    case (idx)
      0:       v = 32'd536870912;
      1:       v = 32'd316933406;
      2:       v = 32'd167458907;
      3:       v = 32'd85004756;
      4:       v = 32'd42667331;
      5:       v = 32'd21354465;
      6:       v = 32'd10679838;
      7:       v = 32'd5340245;
      8:       v = 32'd2670163;
      9:       v = 32'd1335087;
      10:      v = 32'd667544;
      11:      v = 32'd333772;
      12:      v = 32'd166886;
      13:      v = 32'd83443;
      14:      v = 32'd41722;
      15:      v = 32'd20861;
      16:      v = 32'd10430;
      17:      v = 32'd5215;
      18:      v = 32'd2608;
      19:      v = 32'd1304;
      20:      v = 32'd652;
      21:      v = 32'd326;
      22:      v = 32'd163;
      23:      v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/cpc_front.sv */
module cpc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cpc_pkg::in_item_t in_item,
  input  logic              q_ready,
  output logic              q_push,
  output cpc_pkg::work_t    q_data
);

  logic                    front_valid_r, front_valid_nxt;
  cpc_pkg::work_t          front_work_r, front_work_nxt;
  logic                    front_ready;
  logic                    accept;
  cpc_pkg::coord_ext_t     xs, ys;
  cpc_pkg::angle_t         ang;

  // Hand-off to the queue
  assign front_ready = !front_valid_r || q_ready;
  assign accept      = start && front_ready;
  assign busy        = !rst_n || !front_ready;
  assign q_push      = front_valid_r && q_ready;
  assign q_data      = front_work_r;

  // Classify: fold into the right half plane / into a quarter turn
  always_comb begin
    xs  = '0;
    ys  = '0;
    ang = in_item.angle_in;
    front_work_nxt.rot  = (in_item.opcode == cpc_pkg::OP_TO_CART);
    front_work_nxt.zero = 1'b0;
    front_work_nxt.z    = '0;
    if (in_item.opcode == cpc_pkg::OP_TO_CART) begin
      xs = cpc_pkg::coord_ext_t'({1'b0, in_item.radius_in});
      if (ang > cpc_pkg::QUARTER_POS || ang < cpc_pkg::QUARTER_NEG) begin
        // half turn shift is a flip of the angle sign bit
        ang[cpc_pkg::ANGLE_WIDTH-1] = ~ang[cpc_pkg::ANGLE_WIDTH-1];
        xs = -xs;
      end
      front_work_nxt.z = {ang, {(cpc_pkg::Z_W - cpc_pkg::ANGLE_WIDTH){1'b0}}};
    end else begin
      xs = cpc_pkg::coord_ext_t'(in_item.x_in);
      ys = cpc_pkg::coord_ext_t'(in_item.y_in);
      front_work_nxt.zero = (in_item.x_in == '0) && (in_item.y_in == '0);
      if (in_item.x_in < 0) begin
        xs = -xs;
        ys = -ys;
        front_work_nxt.z = {1'b1, {(cpc_pkg::Z_W - 1){1'b0}}};
      end
    end
    front_work_nxt.x = cpc_pkg::data_t'(xs) <<< cpc_pkg::GUARD_BITS;
    front_work_nxt.y = cpc_pkg::data_t'(ys) <<< cpc_pkg::GUARD_BITS;
  end

  // Valid flag
  always_comb begin
    front_valid_nxt = front_valid_r;
    if (accept) begin
      front_valid_nxt = 1'b1;
    end else if (q_push) begin
      front_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_work_r <= front_work_nxt;
    end
  end

endmodule

/* rtl/core/cpc_queue.sv */
module cpc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cpc_pkg::work_t push_data,
  output logic           ready,
  output logic           pop_valid,
  output cpc_pkg::work_t pop_data
);

  cpc_pkg::work_t                 entry_r [cpc_pkg::QUEUE_DEPTH];
  logic [cpc_pkg::PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [cpc_pkg::PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [cpc_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic                           pop;

  localparam logic [cpc_pkg::PTR_W-1:0] LAST_PTR = cpc_pkg::PTR_W'(cpc_pkg::QUEUE_DEPTH - 1);
  localparam logic [cpc_pkg::CNT_W-1:0] FULL_CNT = cpc_pkg::CNT_W'(cpc_pkg::QUEUE_DEPTH);

  // The back end drains one transaction per cycle whenever one is queued
  assign ready     = (count_r != FULL_CNT);
  assign pop_valid = (count_r != '0);
  assign pop       = pop_valid;
  assign pop_data  = entry_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/core/cpc_back.sv */
module cpc_back #(
  parameter int ITERATIONS = cpc_pkg::ITERATIONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  cpc_pkg::work_t     in_work,
  output logic               out_valid,
  output cpc_pkg::out_item_t out_item
);

  localparam cpc_pkg::prod_t GAIN      = cpc_pkg::prod_t'(cpc_pkg::GAIN_Q20);
  localparam cpc_pkg::prod_t ROUND_ADD = cpc_pkg::prod_t'(1) <<< (cpc_pkg::DESCALE_SHIFT - 1);
  localparam cpc_pkg::prod_t RAD_MAX   = cpc_pkg::prod_t'((2 ** cpc_pkg::COORD_WIDTH) - 1);
  localparam cpc_pkg::prod_t S_MAX     = cpc_pkg::prod_t'((2 ** (cpc_pkg::COORD_WIDTH - 1)) - 1);
  localparam cpc_pkg::prod_t S_MIN     = -S_MAX - cpc_pkg::prod_t'(1);
  localparam logic [cpc_pkg::Z_W-1:0] ANG_ROUND = cpc_pkg::Z_W'(2 ** (cpc_pkg::Z_W - cpc_pkg::ANGLE_WIDTH - 1));

  logic           stage_valid_r [ITERATIONS];
  cpc_pkg::work_t stage_r       [ITERATIONS];

  // One CORDIC micro-rotation per stage
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
    logic           vin;
    cpc_pkg::work_t win, wnxt;
    cpc_pkg::data_t dx, dy;
    logic           cw;

    if (i == 0) begin : g_first
      assign vin = in_valid;
      assign win = in_work;
    end else begin : g_next
      assign vin = stage_valid_r[i-1];
      assign win = stage_r[i-1];
    end

    // Vectoring drives y to zero, rotation drives z to zero
    assign cw = win.rot ? win.z[cpc_pkg::Z_W-1] : !win.y[cpc_pkg::DATA_W-1];
    assign dx = win.y >>> i;
    assign dy = win.x >>> i;

    always_comb begin
      wnxt = win;
      if (cw) begin
        wnxt.x = win.x + dx;
        wnxt.y = win.y - dy;
        wnxt.z = win.z + cpc_pkg::atan_entry(i);
      end else begin
        wnxt.x = win.x - dx;
        wnxt.y = win.y + dy;
        wnxt.z = win.z - cpc_pkg::atan_entry(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_valid_r[i] <= 1'b0;
      end else begin
        stage_valid_r[i] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      stage_r[i] <= wnxt;
    end
  end

  // Gain correction multiply
  logic           mul_valid_r;
  cpc_pkg::prod_t mul_x_r, mul_y_r;
  logic           mul_rot_r, mul_zero_r;
  cpc_pkg::z_t    mul_z_r;
  cpc_pkg::work_t last_w;

  assign last_w = stage_r[ITERATIONS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else begin
      mul_valid_r <= stage_valid_r[ITERATIONS-1];
    end
  end

  always_ff @(posedge clk) begin
    mul_x_r    <= cpc_pkg::prod_t'(last_w.x) * GAIN;
    mul_y_r    <= cpc_pkg::prod_t'(last_w.y) * GAIN;
    mul_rot_r  <= last_w.rot;
    mul_zero_r <= last_w.zero;
    mul_z_r    <= last_w.z;
  end

  // Round half up, drop guard bits, saturate, zero the unused fields
  cpc_pkg::prod_t     rx, ry;
  cpc_pkg::z_t        z_rnd;
  cpc_pkg::out_item_t res_nxt;
  logic               out_valid_r;
  cpc_pkg::out_item_t out_item_r;

  always_comb begin
    rx      = (mul_x_r + ROUND_ADD) >>> cpc_pkg::DESCALE_SHIFT;
    ry      = (mul_y_r + ROUND_ADD) >>> cpc_pkg::DESCALE_SHIFT;
    z_rnd   = mul_z_r + ANG_ROUND;
    res_nxt = '0;
    if (mul_rot_r) begin
      if (rx > S_MAX) begin
        res_nxt.x_out = S_MAX[cpc_pkg::COORD_WIDTH-1:0];
      end else if (rx < S_MIN) begin
        res_nxt.x_out = S_MIN[cpc_pkg::COORD_WIDTH-1:0];
      end else begin
        res_nxt.x_out = rx[cpc_pkg::COORD_WIDTH-1:0];
      end
      if (ry > S_MAX) begin
        res_nxt.y_out = S_MAX[cpc_pkg::COORD_WIDTH-1:0];
      end else if (ry < S_MIN) begin
        res_nxt.y_out = S_MIN[cpc_pkg::COORD_WIDTH-1:0];
      end else begin
        res_nxt.y_out = ry[cpc_pkg::COORD_WIDTH-1:0];
      end
    end else if (!mul_zero_r) begin
      if (rx < 0) begin
        res_nxt.radius_out = '0;
      end else if (rx > RAD_MAX) begin
        res_nxt.radius_out = RAD_MAX[cpc_pkg::COORD_WIDTH-1:0];
      end else begin
        res_nxt.radius_out = rx[cpc_pkg::COORD_WIDTH-1:0];
      end
      res_nxt.angle_out = z_rnd[cpc_pkg::Z_W-1 -: cpc_pkg::ANGLE_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/core/cartesian_polar_converter.sv */
// Path: an accepted transaction passes the front register, the queue, the CORDIC stages,
//   the gain multiply register and the output register before out_valid goes high.
// Throughput: one transaction per clock cycle; the unrolled CORDIC stages, one per
//   iteration, each take a new item every cycle, and busy stays low in steady flow.
// Reset: synchronous, active low; clears all valid flags and the queue, busy is high
//   while rst_n is low. Results are strobed once and cannot be stalled.
module cartesian_polar_converter #(
  parameter int ITERATIONS = cpc_pkg::ITERATIONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cpc_pkg::in_item_t  in_item,
  output logic               out_valid,
  output cpc_pkg::out_item_t out_item
);

  localparam int LATENCY = ITERATIONS + 4;

  logic           q_ready;
  logic           q_push;
  cpc_pkg::work_t q_push_data;
  logic           q_pop_valid;
  cpc_pkg::work_t q_pop_data;

  // Front end: accept and classify
  cpc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_data  (q_push_data)
  );

  // Decoupling queue
  cpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .ready     (q_ready),
    .pop_valid (q_pop_valid),
    .pop_data  (q_pop_data)
  );

  // Back end: CORDIC pipeline and gain correction
  cpc_back #(
    .ITERATIONS (ITERATIONS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_pop_valid),
    .in_work   (q_pop_data),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  // Every result comes from a transaction accepted a fixed time before
  a_out_has_source: assert property (@(posedge clk)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without an accepted transaction");

  // Every accepted transaction gives its result on time
  a_in_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted transaction lost");

  // Cartesian and polar fields are never both in use
  a_fields_exclusive: assert property (@(posedge clk)
    (out_valid && (out_item.x_out != '0 || out_item.y_out != '0)) |->
      (out_item.radius_out == '0 && out_item.angle_out == '0))
    else $error("both result formats populated");

  // The front end is free in the first cycle out of reset
  a_ready_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !busy)
    else $error("busy right after reset");
`endif

endmodule
